/* hw/rtl/tsc_pkg.sv */
// Shared types and constants for the Taylor sine/cosine pipeline.
package tsc_pkg;

  // Port field widths.
  localparam int ANGLE_W = 31;
  localparam int VALUE_W = 32;

  // Internal fixed point: signed Q6.58 in 64 bits.
  localparam int WORD_W = 64;
  localparam int IFRAC  = 58;

  // Parameter defaults.
  localparam int TERMS_DEF           = 20;
  localparam int ANGLE_FRAC_BITS_DEF = 28;

  // Pi with 60 fraction bits.
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] ONE_FIX = 64'd1 << IFRAC;

  // Function select codes.
  localparam logic CMD_COS = 1'b0;
  localparam logic CMD_SIN = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;

  // What one pipeline step does with the item flowing through it.
  typedef enum logic [1:0] {
    STEP_SQUARE,
    STEP_FIRST,
    STEP_HORNER,
    STEP_FINAL
  } tsc_step_t;

  // One item in flight: control bits and the series operands.
  typedef struct packed {
    logic  valid;
    logic  cmd;
    logic  neg;
    word_t x;
    word_t x2;
    word_t u;
    word_t p;
  } tsc_item_t;

endpackage

/* hw/rtl/tsc_if.sv */
// Valid/ready channel interfaces for angle input and result output.
interface tsc_in_if;
  import tsc_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [ANGLE_W-1:0] angle;
  modport source (output valid, output cmd, output angle, input ready);
  modport sink   (input valid, input cmd, input angle, output ready);
endinterface

interface tsc_out_if;
  import tsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* hw/rtl/taylor_sine_cosine_unit_top.sv */
// Top level of the pipelined Taylor series sine/cosine unit.
//
// Usage:
//   in_chan carries one transaction per angle: cmd (0 cosine, 1 sine) and
//   angle (signed, ANGLE_FRAC_BITS fraction bits, clamped to plus or minus pi).
//   out_chan returns one transaction per angle: value, signed Q1.30,
//   saturated to plus or minus one, in the order the angles came in.
// Pipeline: the input register loads when an angle is accepted, then TERMS + 2
//   steps of three register stages each (square, first reciprocal product,
//   TERMS - 1 Horner steps, final multiply by x), then the output register.
// Throughput: one transaction per cycle while out_chan is not stalled; each Horner step owns two 3-stage
//   64x64 multipliers built from 32x32 partial products.
// Reset: synchronous, active low; clears every valid bit in the pipeline.
// Stall: while out_chan holds a result that is not taken, the whole pipeline
//   holds and in_chan.ready is low; nothing is lost or repeated.
module taylor_sine_cosine_unit_top #(
  parameter int TERMS           = tsc_pkg::TERMS_DEF,
  parameter int ANGLE_FRAC_BITS = tsc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tsc_in_if.sink   in_chan,
  tsc_out_if.source out_chan
);
  import tsc_pkg::*;

  localparam int          NSTEP  = TERMS + 2;
  localparam int          PI_SH  = 60 - ANGLE_FRAC_BITS;
  localparam logic [63:0] PI_RND = (PI_SH > 0) ? (64'd1 << (PI_SH - 1)) : 64'd0;
  localparam logic [63:0] PI_ANG = (PI_Q60 + PI_RND) >> PI_SH;
  localparam int          SHL    = (ANGLE_FRAC_BITS <= IFRAC) ? IFRAC - ANGLE_FRAC_BITS : 0;
  localparam int          SHR    = (ANGLE_FRAC_BITS >  IFRAC) ? ANGLE_FRAC_BITS - IFRAC : 0;
  localparam int          KF     = TERMS - 1;
  localparam logic [63:0] DF_COS = 64'((2 * KF - 1) * (2 * KF));
  localparam logic [63:0] DF_SIN = 64'((2 * KF) * (2 * KF + 1));
  localparam logic [63:0] RF_COS = ((64'd1 << IFRAC) + DF_COS / 2) / DF_COS;
  localparam logic [63:0] RF_SIN = ((64'd1 << IFRAC) + DF_SIN / 2) / DF_SIN;

  logic        en;
  logic        neg_in;
  logic [31:0] mag;
  logic [63:0] mag_c, xm;
  tsc_item_t   in_r;
  tsc_item_t   item [NSTEP+1];

  logic                      rneg;
  logic [63:0]               tmag;
  logic [36:0]               q;
  logic [30:0]               qs;
  logic                      out_valid_r;
  logic [VALUE_W-1:0]        value_r, value_nxt;

  // Whole pipeline advances unless a finished result is being held.
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // Input conditioning: magnitude, clamp to pi, align to 58 fraction bits.
  always_comb begin
    neg_in = in_chan.angle[ANGLE_W-1];
    mag    = neg_in ? (32'h8000_0000 - {1'b0, in_chan.angle})
                    : {1'b0, in_chan.angle};
    mag_c  = ({32'd0, mag} > PI_ANG) ? PI_ANG : {32'd0, mag};
    xm     = (ANGLE_FRAC_BITS <= IFRAC) ? (mag_c << SHL) : (mag_c >> SHR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid <= 1'b0;
    end else if (en) begin
      in_r.valid <= in_chan.valid;
      in_r.cmd   <= in_chan.cmd;
      in_r.neg   <= neg_in;
      in_r.x     <= word_t'(xm);
      in_r.x2    <= '0;
      in_r.u     <= '0;
      in_r.p     <= '0;
    end
  end

  assign item[0] = in_r;

  // x squared.
  tsc_step #(.MODE(STEP_SQUARE), .R_COS(64'd0), .R_SIN(64'd0)) u_sq (
    .clk(clk), .rst_n(rst_n), .en(en), .item_i(item[0]), .item_o(item[1])
  );

  // First reciprocal product for the innermost Horner term.
  tsc_step #(.MODE(STEP_FIRST), .R_COS(RF_COS), .R_SIN(RF_SIN)) u_first (
    .clk(clk), .rst_n(rst_n), .en(en), .item_i(item[1]), .item_o(item[2])
  );

  // Horner steps; each also forms the reciprocal product for the next one.
  for (genvar gi = 0; gi < TERMS - 1; gi++) begin : g_horner
    localparam int          KN    = TERMS - 2 - gi;
    localparam logic [63:0] DN_C  = (KN > 0) ? 64'((2 * KN - 1) * (2 * KN)) : 64'd1;
    localparam logic [63:0] DN_S  = (KN > 0) ? 64'((2 * KN) * (2 * KN + 1)) : 64'd1;
    localparam logic [63:0] RN_C  = (KN > 0) ? ((64'd1 << IFRAC) + DN_C / 2) / DN_C : 64'd0;
    localparam logic [63:0] RN_S  = (KN > 0) ? ((64'd1 << IFRAC) + DN_S / 2) / DN_S : 64'd0;
    tsc_step #(.MODE(STEP_HORNER), .R_COS(RN_C), .R_SIN(RN_S)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .item_i(item[gi+2]), .item_o(item[gi+3])
    );
  end

  // Final multiply by x for sine; cosine takes the series as it stands.
  tsc_step #(.MODE(STEP_FINAL), .R_COS(64'd0), .R_SIN(64'd0)) u_final (
    .clk(clk), .rst_n(rst_n), .en(en), .item_i(item[NSTEP-1]), .item_o(item[NSTEP])
  );

  // Round to Q1.30, saturate, and put the sign back.
  always_comb begin
    rneg = item[NSTEP].p[63];
    tmag = rneg ? (~item[NSTEP].p + 64'd1) : item[NSTEP].p;
    q    = tmag[63:27] + 37'd1;
    q    = {1'b0, q[36:1]};
    qs   = (q > 37'd1073741824) ? 31'd1073741824 : q[30:0];
    if (item[NSTEP].cmd == CMD_SIN && item[NSTEP].neg) begin
      rneg = !rneg;
    end
    value_nxt = rneg ? (32'd0 - {1'b0, qs}) : {1'b0, qs};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= item[NSTEP].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.value = value_r;

endmodule

/* hw/rtl/tsc_mul.sv */
// Three-stage signed fixed-point multiplier with round-half-away rounding.
module tsc_mul (
  input  logic          clk,
  input  logic          en,
  input  tsc_pkg::word_t a,
  input  tsc_pkg::word_t b,
  output tsc_pkg::word_t p
);
  import tsc_pkg::*;

  logic [63:0]  ua_nxt, ub_nxt, ua_r, ub_r;
  logic         neg_r, neg2_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] sum;
  logic [62:0]  mag;
  word_t        p_nxt, p_r;

  // Stage 1: magnitudes and product sign.
  always_comb begin
    ua_nxt = a[63] ? (~a + 64'd1) : a;
    ub_nxt = b[63] ? (~b + 64'd1) : b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r  <= ua_nxt;
      ub_r  <= ub_nxt;
      neg_r <= a[63] ^ b[63];
    end
  end

  // Stage 2: four 32x32 partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= ua_r[31:0]  * ub_r[31:0];
      p01_r  <= ua_r[31:0]  * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];
      neg2_r <= neg_r;
    end
  end

  // Stage 3: sum, round at the binary point, drop the top bit, restore sign.
  always_comb begin
    sum = {p11_r, 64'd0} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
        + {64'd0, p00_r} + (128'd1 << (IFRAC - 1));
    mag   = sum[IFRAC+62:IFRAC];
    p_nxt = neg2_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

/* hw/rtl/tsc_step.sv */
// One pipeline step of the series evaluation.
module tsc_step #(
  parameter tsc_pkg::tsc_step_t MODE  = tsc_pkg::STEP_HORNER,
  parameter logic [63:0]        R_COS = 64'd0,
  parameter logic [63:0]        R_SIN = 64'd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tsc_pkg::tsc_item_t item_i,
  output tsc_pkg::tsc_item_t item_o
);
  import tsc_pkg::*;

  word_t     a_a, a_b, b_a, b_b, pa, pb, recip;
  tsc_item_t side_r [3];

  // Operand selection for the two multipliers.
  always_comb begin
    recip = (item_i.cmd == CMD_SIN) ? word_t'(R_SIN) : word_t'(R_COS);
    a_a   = item_i.x;
    a_b   = item_i.x;
    b_a   = '0;
    b_b   = '0;
    unique case (MODE)
      STEP_SQUARE: begin
        a_a = item_i.x;
        a_b = item_i.x;
      end
      STEP_FIRST: begin
        a_a = item_i.x2;
        a_b = recip;
      end
      STEP_HORNER: begin
        a_a = item_i.u;
        a_b = word_t'(ONE_FIX) - item_i.p;
        b_a = item_i.x2;
        b_b = recip;
      end
      STEP_FINAL: begin
        a_a = item_i.x;
        a_b = word_t'(ONE_FIX) - item_i.p;
      end
      default: begin
        a_a = item_i.x;
      end
    endcase
  end

  tsc_mul u_mul_a (.clk(clk), .en(en), .a(a_a), .b(a_b), .p(pa));
  tsc_mul u_mul_b (.clk(clk), .en(en), .a(b_a), .b(b_b), .p(pb));

  // Sideband pipe matching the multiplier latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0].valid <= 1'b0;
      side_r[1].valid <= 1'b0;
      side_r[2].valid <= 1'b0;
    end else if (en) begin
      side_r[0] <= item_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
    end
  end

  // Merge products into the outgoing item.
  always_comb begin
    item_o = side_r[2];
    unique case (MODE)
      STEP_SQUARE: item_o.x2 = pa;
      STEP_FIRST: begin
        item_o.u = pa;
        item_o.p = '0;
      end
      STEP_HORNER: begin
        item_o.p = pa;
        item_o.u = pb;
      end
      STEP_FINAL: begin
        item_o.p = (side_r[2].cmd == CMD_SIN) ? pa : word_t'(ONE_FIX) - side_r[2].p;
      end
      default: item_o.p = pa;
    endcase
  end

endmodule

/* hw/rtl/tsc_checker.sv */
// Port-level checks for the sine/cosine unit, bound to the top level.
module tsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value
);

  // A held result keeps its value until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // Results never leave plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_value) <= 32'sd1073741824 &&
                   $signed(out_value) >= -32'sd1073741824))
    else $error("result out of range");

  // A stalled output stops input acceptance.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The pipeline takes input whenever the output moves.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output free");

endmodule

bind taylor_sine_cosine_unit_top tsc_checker u_tsc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_value(out_chan.value)
);

/* dv/taylor_sine_cosine_unit_top_tb.sv */
// Self-checking testbench for the Taylor series sine/cosine unit.
`timescale 1ns / 1ps

module taylor_sine_cosine_unit_top_tb;
  import tsc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 3 * TERMS_DEF + 20;
  localparam int RANDOM_ITEMS  = 300;
  localparam int ANGLE_MAX     = 843314857;
  localparam int MAX_REPORTS   = 10;

  logic clk;
  logic rst_n;

  tsc_in_if  in_chan ();
  tsc_out_if out_chan ();

  taylor_sine_cosine_unit_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Expected series values, oldest first.
  logic [VALUE_W-1:0] expected_values[$];

  int error_count;
  int cycle_count;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_request;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Rounded Q6.58 product of two non-negative values.
  function automatic logic [63:0] mul_round_mag(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    begin
      prod = {64'd0, a} * {64'd0, b};
      prod = prod + (128'd1 << (IFRAC - 1));
      return prod[IFRAC+63:IFRAC];
    end
  endfunction

  // Rounded signed Q6.58 product, sign and magnitude handled apart.
  function automatic logic signed [63:0] mul_round_fix(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
    logic        neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] r;
    begin
      neg = a[63] ^ b[63];
      ua  = a[63] ? -a : a;
      ub  = b[63] ? -b : b;
      r   = mul_round_mag(ua, ub) & 64'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -$signed(r) : $signed(r);
    end
  endfunction

  // Series value in Q1.30 for one angle and function select.
  function automatic logic [VALUE_W-1:0] taylor_value(input logic cmd,
                                                      input logic [ANGLE_W-1:0] angle);
    logic               is_sin;
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        pi_angle;
    logic [63:0]        s;
    logic [63:0]        d;
    logic [63:0]        q;
    logic signed [63:0] x;
    logic signed [63:0] x2;
    logic signed [63:0] t;
    logic signed [63:0] r;
    logic signed [63:0] u;
    logic               rneg;
    begin
      is_sin   = (cmd == CMD_SIN);
      neg      = angle[ANGLE_W-1];
      mag      = neg ? (64'h8000_0000 - {33'd0, angle}) : {33'd0, angle};
      pi_angle = (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS_DEF - 1))) >>
                 (60 - ANGLE_FRAC_BITS_DEF);
      if (mag > pi_angle) begin
        mag = pi_angle;
      end
      x  = $signed(mag << (IFRAC - ANGLE_FRAC_BITS_DEF));
      x2 = mul_round_fix(x, x);
      s  = is_sin ? 64'd1 : 64'd0;
      t  = $signed(ONE_FIX);
      // Horner evaluation from the highest term down.
      for (int k = TERMS_DEF - 1; k >= 1; k--) begin
        d = (2 * k - 1 + s) * (2 * k + s);
        r = $signed((ONE_FIX + d / 2) / d);
        u = mul_round_fix(x2, r);
        t = $signed(ONE_FIX) - mul_round_fix(u, t);
      end
      if (is_sin) begin
        t = mul_round_fix(x, t);
      end
      // Round to Q1.30 and saturate to plus or minus one.
      rneg = t[63];
      q    = rneg ? -t : t;
      q    = (q + (64'd1 << (IFRAC - 31))) >> (IFRAC - 30);
      if (q > (64'd1 << 30)) begin
        q = 64'd1 << 30;
      end
      if (is_sin && neg) begin
        rneg = !rneg;
      end
      return rneg ? -q[31:0] : q[31:0];
    end
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result receiver: random stalls plus long hold-offs on request.
  int hold_left;
  int hold_seen;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_seen != hold_request) begin
      hold_seen      <= hold_request;
      hold_left      <= 300;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result checker: each transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_values.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("ERROR: unexpected result value=%h", out_chan.value);
        end
        error_count <= error_count + 1;
      end else begin
        if (out_chan.value !== expected_values[0]) begin
          if (error_count < MAX_REPORTS) begin
            $display("ERROR: value expected=%h actual=%h",
                     expected_values[0], out_chan.value);
          end
          error_count <= error_count + 1;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  // Offer one angle, with random idle cycles first, and wait for acceptance.
  task automatic send_angle(input logic cmd, input logic [ANGLE_W-1:0] angle);
    begin
      while ($urandom_range(99) < src_idle_pct) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
      in_chan.valid <= 1'b1;
      in_chan.cmd   <= cmd;
      in_chan.angle <= angle;
      @(posedge clk);
      while (!in_chan.ready) begin
        @(posedge clk);
      end
      expected_values.push_back(taylor_value(cmd, angle));
    end
  endtask

  // Angle within plus or minus pi, or now and then any bit pattern.
  function automatic logic [ANGLE_W-1:0] random_angle();
    int v;
    begin
      if ($urandom_range(9) == 0) begin
        return ANGLE_W'($urandom());
      end
      v = $urandom_range(ANGLE_MAX);
      return ANGLE_W'($urandom_range(1) ? -v : v);
    end
  endfunction

  // Extremes, both functions, and angles around the pi clamp.
  task automatic test_directed();
    logic [ANGLE_W-1:0] angles[11];
    begin
      angles = '{31'd0, 31'd1, -31'sd1, ANGLE_W'(ANGLE_MAX), ANGLE_W'(-ANGLE_MAX),
                 ANGLE_W'(ANGLE_MAX - 1), ANGLE_W'(ANGLE_MAX + 1),
                 ANGLE_W'(-(ANGLE_MAX + 1)), 31'h3FFF_FFFF, 31'h4000_0000,
                 31'd421657428};
      foreach (angles[i]) begin
        send_angle(CMD_COS, angles[i]);
        send_angle(CMD_SIN, angles[i]);
      end
    end
  endtask

  task automatic test_random(input int items);
    begin
      repeat (items) begin
        send_angle(1'($urandom_range(1)), random_angle());
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, filling the pipeline.
  task automatic test_backpressure();
    begin
      hold_request = hold_request + 1;
      test_random(150);
    end
  endtask

  initial begin
    int drain;
    error_count    = 0;
    cycle_count    = 0;
    hold_request   = 0;
    hold_seen      = 0;
    hold_left      = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.cmd    = CMD_COS;
    in_chan.angle  = '0;
    out_chan.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct   = 18;
    sink_stall_pct = 87;
    test_directed();
    test_random(RANDOM_ITEMS);
    src_idle_pct   = 87;
    sink_stall_pct = 18;
    test_random(RANDOM_ITEMS);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_backpressure();
    test_random(RANDOM_ITEMS - 150);
    in_chan.valid <= 1'b0;

    // Drain the pipeline, then allow a few extra cycles for stray results.
    while (expected_values.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    drain = error_count;
    if (drain == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
